### rtl/hgss_pkg.sv
package hgss_pkg;

   // time arithmetic wraps at this width
   localparam int TIME_W     = 32;
   localparam int TEMP_W     = 15;
   localparam int GAS_W      = 10;
   localparam int HYST_W     = 10;
   localparam int SLOPE_W    = 11;
   localparam int MS_W       = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAS_LEVEL  = 3'd0,
      CSR_HYST       = 3'd1,
      CSR_SLOPE      = 3'd2,
      CSR_PULSE_LEN  = 3'd3,
      CSR_SLOPE_IVL  = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      MODE_STANDBY  = 4'b0001,
      MODE_PREHEAT  = 4'b0010,
      MODE_MAINTAIN = 4'b0100,
      MODE_ESTOP    = 4'b1000
   } mode_type;

   localparam logic [1:0] MODE_CODE_STANDBY  = 2'd0;
   localparam logic [1:0] MODE_CODE_PREHEAT  = 2'd1;
   localparam logic [1:0] MODE_CODE_MAINTAIN = 2'd2;
   localparam logic [1:0] MODE_CODE_ESTOP    = 2'd3;

   typedef struct packed {
      logic [GAS_W-1:0]          gas_alarm_level;
      logic [HYST_W-1:0]         hysteresis_cdeg;
      logic signed [SLOPE_W-1:0] slope_limit;
      logic [MS_W-1:0]           pulse_length_ms;
      logic [MS_W-1:0]           slope_interval_ms;
   } csr_type;

   // packed so that now_ms lands in the lowest bits of tdata
   typedef struct packed {
      logic                     hw_stop;
      logic [GAS_W-1:0]         gas_level;
      logic signed [TEMP_W-1:0] setpoint_cdeg;
      logic signed [TEMP_W-1:0] temperature_cdeg;
      logic [TIME_W-1:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic       stop_message;
      logic       gas_warning;
      logic       siren_on;
      logic       red_led;
      logic       green_led;
      logic       heater_on;
      logic [1:0] mode;
   } rsp_type;

   typedef struct packed {
      logic interval_due;
      logic falling;
      logic pulse_done;
   } slope_type;

   function automatic logic [1:0] mode_code(mode_type m);
      logic [1:0] code;
      unique case (m)
         MODE_STANDBY:  code = MODE_CODE_STANDBY;
         MODE_PREHEAT:  code = MODE_CODE_PREHEAT;
         MODE_MAINTAIN: code = MODE_CODE_MAINTAIN;
         default:       code = MODE_CODE_ESTOP;
      endcase
      return code;
   endfunction

endpackage

### rtl/hgss_csr.sv
module hgss_csr
   import hgss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_type               csr
);

   csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAS_LEVEL: csr_in.gas_alarm_level   = csr_wdata[GAS_W-1:0];
            CSR_HYST:      csr_in.hysteresis_cdeg   = csr_wdata[HYST_W-1:0];
            CSR_SLOPE:     csr_in.slope_limit       = $signed(csr_wdata[SLOPE_W-1:0]);
            CSR_PULSE_LEN: csr_in.pulse_length_ms   = csr_wdata[MS_W-1:0];
            CSR_SLOPE_IVL: csr_in.slope_interval_ms = csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gas_alarm_level   <= GAS_W'(700);
         csr_ff.hysteresis_cdeg   <= HYST_W'(50);
         csr_ff.slope_limit       <= -SLOPE_W'(5);
         csr_ff.pulse_length_ms   <= MS_W'(2000);
         csr_ff.slope_interval_ms <= MS_W'(2000);
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

### rtl/hgss_slope.sv
module hgss_slope
   import hgss_pkg::*;
(
   input  csr_type                  csr,
   input  logic [TIME_W-1:0]        now_ms,
   input  logic signed [TEMP_W-1:0] temperature_cdeg,
   input  logic signed [TEMP_W-1:0] last_temp,
   input  logic [TIME_W-1:0]        last_eval_ms,
   input  logic [TIME_W-1:0]        pulse_start_ms,
   output slope_type                slope
);

   localparam int DIFF_W = TEMP_W + 1;
   localparam int LHS_W  = DIFF_W + 10;
   localparam int RHS_W  = SLOPE_W + TIME_W + 1;
   localparam logic signed [LHS_W-1:0] MS_PER_S = LHS_W'(1000);

   logic [TIME_W-1:0]        dt;
   logic [TIME_W-1:0]        pulse_age;
   logic [MS_W-1:0]          interval;
   logic signed [DIFF_W-1:0] diff;
   logic signed [LHS_W-1:0]  lhs;
   logic signed [RHS_W-1:0]  rhs;

   always_comb begin
      dt        = now_ms - last_eval_ms;
      pulse_age = now_ms - pulse_start_ms;
      interval  = (csr.slope_interval_ms == '0) ? MS_W'(1) : csr.slope_interval_ms;
      diff      = DIFF_W'(temperature_cdeg) - DIFF_W'(last_temp);
      // cross-multiplied slope test: diff / dt < limit / 1000
      lhs       = LHS_W'(diff) * MS_PER_S;
      rhs       = RHS_W'(csr.slope_limit) * $signed({{(RHS_W-TIME_W){1'b0}}, dt});

      slope.interval_due = dt >= TIME_W'(interval);
      slope.pulse_done   = pulse_age >= TIME_W'(csr.pulse_length_ms);
      slope.falling      = RHS_W'(lhs) < rhs;
   end

endmodule

### rtl/hgss_ctrl.sv
module hgss_ctrl
   import hgss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  csr_type csr,
   output rsp_type result
);

   localparam int BAND_W = TEMP_W + 2;

   mode_type                 mode_ff, mode_in;
   mode_type                 saved_ff, saved_in;
   logic                     alarm_ff, alarm_in;
   logic                     heater_ff, heater_in;
   logic                     green_ff, green_in;
   logic                     red_ff, red_in;
   logic signed [TEMP_W-1:0] last_temp_ff, last_temp_in;
   logic [TIME_W-1:0]        last_eval_ff, last_eval_in;
   logic [TIME_W-1:0]        pulse_start_ff, pulse_start_in;
   logic                     pulse_ff, pulse_in;
   logic                     shown_ff, shown_in;

   mode_type                 mode_work;
   mode_type                 mode_sel;
   logic                     siren;
   logic                     warn;
   logic                     msg;
   logic                     estop;
   logic                     below_sp;
   logic                     below_band;
   logic signed [BAND_W-1:0] band_low;
   slope_type                slope;

   hgss_slope u_slope (
      .csr              (csr),
      .now_ms           (item.now_ms),
      .temperature_cdeg (item.temperature_cdeg),
      .last_temp        (last_temp_ff),
      .last_eval_ms     (last_eval_ff),
      .pulse_start_ms   (pulse_start_ff),
      .slope            (slope)
   );

   always_comb begin
      below_sp   = item.temperature_cdeg < item.setpoint_cdeg;
      band_low   = BAND_W'(item.setpoint_cdeg)
                 - $signed({{(BAND_W-HYST_W){1'b0}}, csr.hysteresis_cdeg});
      below_band = BAND_W'(item.temperature_cdeg) < band_low;
   end

   always_comb begin
      mode_in        = mode_ff;
      saved_in       = saved_ff;
      alarm_in       = alarm_ff;
      heater_in      = heater_ff;
      green_in       = green_ff;
      red_in         = red_ff;
      last_temp_in   = last_temp_ff;
      last_eval_in   = last_eval_ff;
      pulse_start_in = pulse_start_ff;
      pulse_in       = pulse_ff;
      shown_in       = shown_ff;
      siren          = 1'b0;
      warn           = 1'b0;
      msg            = 1'b0;
      estop          = 1'b0;

      // hardware stop latches before anything else is looked at
      mode_work = item.hw_stop ? MODE_ESTOP : mode_ff;
      mode_sel  = alarm_ff ? saved_ff : mode_work;
      mode_in   = mode_work;

      if (mode_work == MODE_ESTOP) begin
         estop = 1'b1;
      end else if (item.gas_level >= csr.gas_alarm_level) begin
         if (!alarm_ff) begin
            saved_in = mode_work;
            alarm_in = 1'b1;
         end
         heater_in = 1'b0;
         green_in  = 1'b0;
         red_in    = 1'b1;
         siren     = 1'b1;
         warn      = 1'b1;
      end else begin
         alarm_in = 1'b0;
         mode_in  = mode_sel;
         green_in = 1'b1;
         red_in   = 1'b0;
         unique case (mode_sel)
            MODE_STANDBY: begin
               green_in     = 1'b0;
               heater_in    = 1'b0;
               last_temp_in = item.temperature_cdeg;
               if (below_sp) begin
                  mode_in = MODE_PREHEAT;
               end
            end
            MODE_PREHEAT: begin
               green_in  = 1'b0;
               red_in    = 1'b1;
               heater_in = 1'b1;
               if (!below_sp) begin
                  mode_in      = MODE_MAINTAIN;
                  last_eval_in = item.now_ms;
                  last_temp_in = item.temperature_cdeg;
                  heater_in    = 1'b0;
               end
            end
            MODE_MAINTAIN: begin
               if (pulse_ff) begin
                  if (slope.pulse_done) begin
                     heater_in = 1'b0;
                     pulse_in  = 1'b0;
                  end
               end else if (slope.interval_due) begin
                  last_eval_in = item.now_ms;
                  last_temp_in = item.temperature_cdeg;
                  if (slope.falling && below_sp) begin
                     heater_in      = 1'b1;
                     pulse_start_in = item.now_ms;
                     pulse_in       = 1'b1;
                  end
               end
               if (below_band) begin
                  mode_in = MODE_PREHEAT;
               end
            end
            default: begin
               estop = 1'b1;
            end
         endcase
      end

      if (estop) begin
         heater_in = 1'b0;
         green_in  = 1'b0;
         red_in    = 1'b1;
         siren     = 1'b1;
         msg       = !shown_ff;
         shown_in  = 1'b1;
      end

      result.mode         = mode_code(mode_in);
      result.heater_on    = heater_in;
      result.green_led    = green_in;
      result.red_led      = red_in;
      result.siren_on     = siren;
      result.gas_warning  = warn;
      result.stop_message = msg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_STANDBY;
         saved_ff       <= MODE_STANDBY;
         alarm_ff       <= 1'b0;
         heater_ff      <= 1'b0;
         green_ff       <= 1'b0;
         red_ff         <= 1'b0;
         last_temp_ff   <= '0;
         last_eval_ff   <= '0;
         pulse_start_ff <= '0;
         pulse_ff       <= 1'b0;
         shown_ff       <= 1'b0;
      end else if (step) begin
         mode_ff        <= mode_in;
         saved_ff       <= saved_in;
         alarm_ff       <= alarm_in;
         heater_ff      <= heater_in;
         green_ff       <= green_in;
         red_ff         <= red_in;
         last_temp_ff   <= last_temp_in;
         last_eval_ff   <= last_eval_in;
         pulse_start_ff <= pulse_start_in;
         pulse_ff       <= pulse_in;
         shown_ff       <= shown_in;
      end
   end

endmodule

### rtl/heater_gas_safety_supervisor_core.sv
// a tick accepted into the input register moves on to the result register,
// and its result beat can be taken from there
// throughput: one tick per cycle unless the output stalls; the input register and the result
// register each hold one beat, and the mode/actuator state updates as a tick moves between them
// reset (synchronous, active high): standby, all actuators off, alarm and stop latches
// cleared, registers back to their defaults; only reset leaves the emergency stop
module heater_gas_safety_supervisor_core
   import hgss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms[31:0], temperature_cdeg[46:32], setpoint_cdeg[61:47], gas_level[71:62],
   // hw_stop[72], zero fill [79:73]
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // mode[1:0], heater_on[2], green_led[3], red_led[4], siren_on[5], gas_warning[6],
   // stop_message[7]
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_type csr;
   req_type in_item_ff, in_item_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type result;
   logic    advance;
   logic    req_fire;

   hgss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   hgss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .csr    (csr),
      .result (result)
   );

   always_comb begin
      advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;
      req_fire   = req_tvalid && req_tready;

      in_item_in  = req_fire ? req_type'(req_tdata[$bits(req_type)-1:0]) : in_item_ff;
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

      out_data_in  = advance ? result : out_data_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   // a tick that moves to the result stage is always presented on the next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("result beat missing after advance");

   // a tick held in the input register is not dropped while the output is blocked
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |=> in_valid_ff)
      else $error("input beat lost while output stalled");

   // a gas alarm beat never drives the heater and always sounds the siren
   a_gas_safe: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.gas_warning)
         |-> (out_data_ff.siren_on && !out_data_ff.heater_on && out_data_ff.red_led))
      else $error("gas alarm beat with unsafe actuators");

   // the stop message only comes with the emergency stop mode and safe outputs
   a_stop_msg: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.stop_message)
         |-> (out_data_ff.mode == MODE_CODE_ESTOP && !out_data_ff.heater_on
              && out_data_ff.siren_on))
      else $error("stop message outside emergency stop");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import hgss_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   heater_gas_safety_supervisor_core uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // supervisor state as predicted from the accepted ticks
   logic [1:0]        cur_mode = MODE_CODE_STANDBY;
   logic [1:0]        saved_mode = MODE_CODE_STANDBY;
   bit                alarm_latched, heater, green, red, pulse_active, msg_shown;
   int                last_temp;
   logic [TIME_W-1:0] last_eval = '0;
   logic [TIME_W-1:0] pulse_start = '0;

   // register copies, reset values
   logic [GAS_W-1:0]  alarm_level = 10'd700;
   int                hyst_cdeg = 50;
   int                slope_lim = -5;
   logic [MS_W-1:0]   pulse_len = 16'd2000;
   logic [MS_W-1:0]   slope_ivl = 16'd2000;

   logic [REQ_DATA_W-1:0] pending_ticks[$];
   rsp_type               expected_status[$];

   bit  req_taken;
   bit  idle_req = 1'b1, idle_rsp = 1'b1;
   int  req_gap, rsp_stall;
   int  errors, results_checked, ticks_accepted, alarm_ticks, pulses, stops_seen, settings;

   logic [TIME_W-1:0] sim_ms = '0;
   int                env_temp, env_sp;

   task automatic supervise_tick(input req_type tick, output rsp_type status);
      int                t, sp;
      logic [TIME_W-1:0] dt, since_pulse, ivl_eff;
      longint            lhs, rhs, dt_wide;
      bit                siren, warn, stopping;
      t = tick.temperature_cdeg;
      sp = tick.setpoint_cdeg;
      siren = 1'b0;
      warn = 1'b0;
      stopping = 1'b0;
      status = '0;
      if (tick.hw_stop)
         cur_mode = MODE_CODE_ESTOP;
      if (cur_mode == MODE_CODE_ESTOP) begin
         stopping = 1'b1;
      end else if (tick.gas_level >= alarm_level) begin
         if (!alarm_latched) begin
            saved_mode = cur_mode;
            alarm_latched = 1'b1;
         end
         heater = 1'b0;
         green = 1'b0;
         red = 1'b1;
         siren = 1'b1;
         warn = 1'b1;
         alarm_ticks++;
      end else begin
         if (alarm_latched) begin
            cur_mode = saved_mode;
            alarm_latched = 1'b0;
         end
         green = 1'b1;
         red = 1'b0;
         case (cur_mode)
            MODE_CODE_STANDBY: begin
               green = 1'b0;
               heater = 1'b0;
               last_temp = t;
               if (t < sp)
                  cur_mode = MODE_CODE_PREHEAT;
            end
            MODE_CODE_PREHEAT: begin
               green = 1'b0;
               red = 1'b1;
               heater = 1'b1;
               if (t >= sp) begin
                  cur_mode = MODE_CODE_MAINTAIN;
                  last_eval = tick.now_ms;
                  last_temp = t;
                  heater = 1'b0;
               end
            end
            MODE_CODE_MAINTAIN: begin
               if (pulse_active) begin
                  since_pulse = tick.now_ms - pulse_start;
                  if (since_pulse >= pulse_len) begin
                     heater = 1'b0;
                     pulse_active = 1'b0;
                  end
               end else begin
                  dt = tick.now_ms - last_eval;
                  ivl_eff = (slope_ivl == 0) ? 1 : slope_ivl;
                  if (dt >= ivl_eff) begin
                     // slope test without division: diff/dt < limit/1000
                     dt_wide = dt;
                     lhs = longint'(t - last_temp) * 1000;
                     rhs = slope_lim * dt_wide;
                     last_eval = tick.now_ms;
                     last_temp = t;
                     if (lhs < rhs && t < sp) begin
                        heater = 1'b1;
                        pulse_start = tick.now_ms;
                        pulse_active = 1'b1;
                        pulses++;
                     end
                  end
               end
               if (t < sp - hyst_cdeg)
                  cur_mode = MODE_CODE_PREHEAT;
            end
            default: stopping = 1'b1;
         endcase
      end
      if (stopping) begin
         heater = 1'b0;
         green = 1'b0;
         red = 1'b1;
         siren = 1'b1;
         status.stop_message = !msg_shown;
         msg_shown = 1'b1;
         stops_seen += status.stop_message;
      end
      status.mode = cur_mode;
      status.heater_on = heater;
      status.green_led = green;
      status.red_led = red;
      status.siren_on = siren;
      status.gas_warning = warn;
   endtask

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         errors++;
         $error("%s: expected %0d, got %0d", field, want, got);
      end
   endtask

   function automatic int idle_length(bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   function automatic int rand_temp();
      return int'($urandom_range(0, 18000)) - 5500;
   endfunction

   // tick driver: holds a beat until taken, then an optional gap
   always @(negedge clock) begin : tick_driver
      logic                  next_valid;
      logic [REQ_DATA_W-1:0] next_data;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         next_data = req_tdata;
         if (req_tvalid && req_taken)
            next_valid = 1'b0;
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_ticks.size() != 0) begin
               next_data = pending_ticks.pop_front();
               next_valid = 1'b1;
               req_gap = idle_length(idle_req);
            end
         end
         req_tvalid <= next_valid;
         req_tdata <= next_data;
      end
   end

   always @(negedge clock) begin : status_ready
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = idle_length(idle_rsp);
      end
   end

   always @(posedge clock) begin : monitor
      req_type seen;
      rsp_type want, got;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen = req_tdata[$bits(req_type)-1:0];
            supervise_tick(seen, want);
            expected_status.push_back(want);
            ticks_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_status.size() == 0) begin
               errors++;
               $error("status beat with no tick outstanding: %h", got);
            end else begin
               want = expected_status.pop_front();
               results_checked++;
               check_field("mode", want.mode, got.mode);
               check_field("heater_on", want.heater_on, got.heater_on);
               check_field("green_led", want.green_led, got.green_led);
               check_field("red_led", want.red_led, got.red_led);
               check_field("siren_on", want.siren_on, got.siren_on);
               check_field("gas_warning", want.gas_warning, got.gas_warning);
               check_field("stop_message", want.stop_message, got.stop_message);
            end
         end
      end
   end

   task automatic push_tick(input logic [TIME_W-1:0] now, input int t, input int sp,
                            input logic [GAS_W-1:0] gas, input logic stop);
      req_type tick;
      tick.now_ms = now;
      tick.temperature_cdeg = t[TEMP_W-1:0];
      tick.setpoint_cdeg = sp[TEMP_W-1:0];
      tick.gas_level = gas;
      tick.hw_stop = stop;
      pending_ticks.push_back({{(REQ_DATA_W-$bits(req_type)){1'b0}}, tick});
   endtask

   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_tvalid || expected_status.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GAS_LEVEL: alarm_level = value[GAS_W-1:0];
         CSR_HYST:      hyst_cdeg = value[HYST_W-1:0];
         CSR_SLOPE:     slope_lim = $signed(value[SLOPE_W-1:0]);
         CSR_PULSE_LEN: pulse_len = value;
         CSR_SLOPE_IVL: slope_ivl = value;
         default: ;
      endcase
   endtask

   // one register setting followed by a temperature walk around a setpoint
   task automatic run_phase(input int lvl, input int hyst, input int slope, input int plen,
                            input int ivl_ms, input int count, input bit gaps, input bit stalls);
      int               roll, step, ivl_eff, alarm_run;
      logic [GAS_W-1:0] gas;
      wait_idle();
      write_csr(CSR_GAS_LEVEL, CSR_DATA_W'(lvl));
      write_csr(CSR_HYST, CSR_DATA_W'(hyst));
      write_csr(CSR_SLOPE, CSR_DATA_W'(slope));
      write_csr(CSR_PULSE_LEN, CSR_DATA_W'(plen));
      write_csr(CSR_SLOPE_IVL, CSR_DATA_W'(ivl_ms));
      idle_req = gaps;
      idle_rsp = stalls;
      settings++;
      ivl_eff = (ivl_ms == 0) ? 1 : ivl_ms;
      alarm_run = 0;
      env_sp = rand_temp();
      env_temp = env_sp - int'($urandom_range(0, 3000));
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            env_temp = rand_temp();
            if (roll < 2)
               env_sp = rand_temp();
         end else if (roll < 10) begin
            env_temp -= int'($urandom_range(50, 2500));
         end else if (roll < 16) begin
            env_temp += int'($urandom_range(50, 600));
         end else if (env_temp < env_sp) begin
            env_temp += int'($urandom_range(0, 160));
         end else begin
            env_temp += int'($urandom_range(0, 110)) - 80;
         end
         if (env_temp < -5500)
            env_temp = -5500;
         if (env_temp > 12500)
            env_temp = 12500;

         roll = $urandom_range(0, 99);
         if (roll < 85)
            step = $urandom_range(0, ivl_eff + ivl_eff / 2 + 5);
         else if (roll < 97)
            step = $urandom_range(0, plen + 20);
         else
            step = $urandom;
         sim_ms += step;

         roll = $urandom_range(0, 99);
         if (lvl == 0) begin
            gas = $urandom_range(0, 1023);
         end else if (alarm_run > 0) begin
            gas = $urandom_range(lvl, 1023);
            alarm_run--;
         end else if (roll < 4) begin
            gas = $urandom_range(lvl, 1023);
            alarm_run = $urandom_range(1, 6);
         end else if (roll < 6) begin
            gas = $urandom_range(0, 1023);
         end else begin
            gas = $urandom_range(0, lvl - 1);
         end
         push_tick(sim_ms, env_temp, env_sp, gas, 1'b0);
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: alarm in each mode, pulse start and end, wrap, pulse left running
      push_tick(32'd0, 2000, 1000, 10'd1023, 1'b0);
      push_tick(32'd10, 2000, 1000, 10'd0, 1'b0);
      push_tick(32'd20, -5500, 12500, 10'd699, 1'b0);
      push_tick(32'd30, 0, 12500, 10'd700, 1'b0);
      push_tick(32'd40, 12500, 12500, 10'd5, 1'b0);
      push_tick(32'd2040, 12460, 12500, 10'd0, 1'b0);
      push_tick(32'd3000, 12460, 12500, 10'd0, 1'b0);
      push_tick(32'd4040, 12470, 12500, 10'd0, 1'b0);
      push_tick(32'd4100, 12470, 12500, 10'd1023, 1'b0);
      push_tick(32'd4200, 12470, 12500, 10'd0, 1'b0);
      push_tick(32'd4300, 12449, 12500, 10'd0, 1'b0);
      push_tick(32'hFFFF_FF00, 12500, 12500, 10'd0, 1'b0);
      push_tick(32'h0000_0900, 12480, 12500, 10'd0, 1'b0);
      push_tick(32'h0000_0A00, -5500, 12500, 10'd0, 1'b0);
      push_tick(32'h0000_0B00, 12500, 12500, 10'd0, 1'b0);
      push_tick(32'h0000_1200, 12500, 12500, 10'd0, 1'b0);
      push_tick(32'hFFFF_FFFF, 12500, -5500, 10'd0, 1'b0);
      push_tick(32'h7FFF_FFFF, -5500, -5500, 10'd0, 1'b0);
      sim_ms = 32'h7FFF_FFFF;

      run_phase(700, 50, -5, 2000, 2000, 250, 1'b1, 1'b1);
      run_phase(1023, 0, -1000, 0, 0, 200, 1'b1, 1'b0);
      run_phase(512, 1000, 1000, 65535, 65535, 200, 1'b0, 1'b1);
      run_phase(0, 10, 0, 100, 1, 30, 1'b1, 1'b1);
      for (int p = 0; p < 5; p++)
         run_phase($urandom_range(400, 1023), $urandom_range(0, 1000),
                   int'($urandom_range(0, 2000)) - 1000,
                   ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5000) : $urandom_range(0, 65535),
                   ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5000) : $urandom_range(0, 65535),
                   200, p % 3 != 1, p % 3 != 2);

      // hardware stop latches for the rest of the run
      push_tick(sim_ms + 100, env_temp, env_sp, 10'd0, 1'b1);
      push_tick(sim_ms + 200, env_temp, env_sp, 10'd1023, 1'b0);
      push_tick(sim_ms + 300, -5500, 12500, 10'd0, 1'b0);
      push_tick(sim_ms + 400, 12500, -5500, 10'd0, 1'b1);
      for (int n = 0; n < 4; n++)
         push_tick($urandom, rand_temp(), rand_temp(), $urandom_range(0, 1023),
                   $urandom_range(0, 1));

      wait_idle();
      $display("checked %0d status beats from %0d ticks over %0d register settings",
               results_checked, ticks_accepted, settings);
      $display("gas alarm ticks %0d, heating pulses %0d, emergency stop entries %0d",
               alarm_ticks, pulses, stops_seen);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
rtl/hgss_pkg.sv
rtl/hgss_csr.sv
rtl/hgss_slope.sv
rtl/hgss_ctrl.sv
rtl/heater_gas_safety_supervisor_core.sv
dv/tb.sv
